FILE: design/radio_channel_frame_decoder_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the radio channel frame decoder
// Used by the design files that carry concurrent checks.
// ---------------------------------------------------------------------------
`ifndef RADIO_CHANNEL_FRAME_DECODER_DEFINES_SVH
`define RADIO_CHANNEL_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, checked at every clock edge out of reset.
`define RCFD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge out of reset.
`define RCFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/rcfd_pkg.sv
// ---------------------------------------------------------------------------
// rcfd_pkg
// Types, constants and the CRC step shared by the frame decoder modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rcfd_pkg;

  localparam int          FRAME_LEN        = 27;
  localparam int          CRC_LAST_BYTE    = 24;
  localparam logic [7:0]  START_MARK       = 8'hA1;
  localparam logic [15:0] CRC_POLY         = 16'h1021;
  localparam logic [15:0] CRC_TOP          = 16'h8000;
  localparam logic [14:0] VALUE_OFFSET     = 15'd977;
  localparam logic [15:0] GAP_RESET        = 16'd3000;
  localparam int          NUM_CHANNELS_DEF = 12;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_LIMIT = 2'd1;

  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_BYTE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_CHANNEL     = 2'd0,
    ST_BAD_START   = 2'd1,
    ST_CRC_FAIL    = 2'd2,
    ST_NO_CHANNELS = 2'd3
  } status_t;

  // One completed frame handed from front to back. ST_CHANNEL marks a good frame.
  typedef struct packed {
    status_t     status;
    logic        bank;
    logic [31:0] frame_drops;
    logic [31:0] crc_drops;
  } desc_t;

  typedef struct packed {
    status_t     status;
    logic [3:0]  channel_index;
    logic [14:0] channel_value;
    logic        last;
    logic [31:0] frame_drops;
    logic [31:0] crc_drops;
  } result_t;

  // CRC-16 CCITT, MSB first, one byte.
  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: design/rcfd_ram.sv
// ---------------------------------------------------------------------------
// rcfd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rcfd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/rcfd_fifo.sv
// ---------------------------------------------------------------------------
// rcfd_fifo
// Two-entry queue of completed frame descriptors between front and back.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radio_channel_frame_decoder_defines.svh"

module rcfd_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rcfd_pkg::desc_t push_desc,
  input  logic            pop,
  output logic            empty,
  output logic            full,
  output rcfd_pkg::desc_t head
);

  rcfd_pkg::desc_t entry_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;

  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_desc;
    end
  end

  `RCFD_ASSERT_IMPLY(a_fifo_no_overflow, push, !full, "frame queue overflow")
  `RCFD_ASSERT_IMPLY(a_fifo_no_underflow, pop, !empty, "frame queue underflow")

endmodule

FILE: design/rcfd_front.sv
// ---------------------------------------------------------------------------
// rcfd_front
// Takes ticks and bytes, tracks gaps, CRC and frame position, stores
// channel words and queues one descriptor per completed frame.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radio_channel_frame_decoder_defines.svh"

module rcfd_front #(
  parameter int NUM_CHANNELS = rcfd_pkg::NUM_CHANNELS_DEF,
  localparam int IDXW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  rcfd_pkg::func_t     in_func,
  input  logic [7:0]          in_byte,
  output logic                in_ready,
  input  logic [15:0]         gap_limit,
  output logic                push,
  output rcfd_pkg::desc_t     push_desc,
  output logic                ram_we,
  output logic [IDXW:0]       ram_waddr,
  output logic [15:0]         ram_wdata,
  input  logic                frame_done
);

  logic [15:0] idle_r, idle_nxt;
  logic [4:0]  pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        start_ok_r, start_ok_nxt;
  logic [7:0]  hi_r, hi_nxt;
  logic        bank_r, bank_nxt;
  logic [31:0] fdrops_r, fdrops_nxt;
  logic [31:0] cdrops_r, cdrops_nxt;
  logic [1:0]  pending_r, pending_nxt;

  logic        is_byte, is_tick, gap_drop, frame_end, bad_start, crc_bad;
  logic [4:0]  pos_eff;
  logic [15:0] crc_base, crc_new;
  logic [3:0]  widx;

  // At most two frames in flight: one per RAM bank.
  assign in_ready = (pending_r < 2'd2);

  always_comb begin
    is_byte   = in_valid && in_ready && (in_func == rcfd_pkg::FUNC_BYTE);
    is_tick   = in_valid && in_ready && (in_func == rcfd_pkg::FUNC_TICK);
    gap_drop  = is_byte && (idle_r > gap_limit) && (pos_r != 5'd0);
    pos_eff   = gap_drop ? 5'd0 : pos_r;
    crc_base  = (pos_eff == 5'd0) ? 16'h0000 : crc_r;
    crc_new   = rcfd_pkg::crc_add(crc_base, in_byte);
    frame_end = is_byte && (pos_eff == 5'(rcfd_pkg::FRAME_LEN - 1));
    bad_start = !start_ok_r;
    crc_bad   = (crc_r != {hi_r, in_byte});
    widx      = pos_eff[4:1] - 4'd1;

    ram_we    = is_byte && !pos_eff[0] && (pos_eff >= 5'd2)
                && (pos_eff <= 5'(rcfd_pkg::CRC_LAST_BYTE))
                && (widx < 4'(NUM_CHANNELS));
    ram_waddr = {bank_r, widx[IDXW-1:0]};
    ram_wdata = {hi_r, in_byte};

    idle_nxt     = idle_r;
    pos_nxt      = pos_r;
    crc_nxt      = crc_r;
    start_ok_nxt = start_ok_r;
    hi_nxt       = hi_r;
    bank_nxt     = bank_r;
    fdrops_nxt   = fdrops_r;
    cdrops_nxt   = cdrops_r;

    if (is_tick && (idle_r != 16'hFFFF)) begin
      idle_nxt = idle_r + 16'd1;
    end

    if (is_byte) begin
      idle_nxt = 16'd0;
      pos_nxt  = frame_end ? 5'd0 : pos_eff + 5'd1;
      if (pos_eff <= 5'(rcfd_pkg::CRC_LAST_BYTE)) begin
        crc_nxt = crc_new;
      end
      if (pos_eff == 5'd0) begin
        start_ok_nxt = (in_byte == rcfd_pkg::START_MARK);
      end
      // high byte of a channel word, or the high CRC byte
      if (pos_eff[0]) begin
        hi_nxt = in_byte;
      end
      if (gap_drop) begin
        fdrops_nxt = fdrops_r + 32'd1;
      end
    end

    push_desc.bank = bank_r;
    push_desc.status = rcfd_pkg::ST_CHANNEL;
    if (frame_end) begin
      bank_nxt = !bank_r;
      if (bad_start) begin
        push_desc.status = rcfd_pkg::ST_BAD_START;
        fdrops_nxt = fdrops_r + 32'd1;
      end else if (crc_bad) begin
        push_desc.status = rcfd_pkg::ST_CRC_FAIL;
        cdrops_nxt = cdrops_r + 32'd1;
      end
    end
    push_desc.frame_drops = fdrops_nxt;
    push_desc.crc_drops   = cdrops_nxt;
    push = frame_end;

    pending_nxt = pending_r + {1'b0, frame_end} - {1'b0, frame_done};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_r     <= 16'd0;
      pos_r      <= 5'd0;
      crc_r      <= 16'd0;
      bank_r     <= 1'b0;
      fdrops_r   <= 32'd0;
      cdrops_r   <= 32'd0;
      pending_r  <= 2'd0;
    end else begin
      idle_r     <= idle_nxt;
      pos_r      <= pos_nxt;
      crc_r      <= crc_nxt;
      bank_r     <= bank_nxt;
      fdrops_r   <= fdrops_nxt;
      cdrops_r   <= cdrops_nxt;
      pending_r  <= pending_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_ok_r <= start_ok_nxt;
    hi_r       <= hi_nxt;
  end

  `RCFD_ASSERT_IMPLY(a_pending_range, 1'b1, pending_r <= 2'd2, "frames in flight above two")
  `RCFD_ASSERT_NEXT(a_restart_after_end, push, pos_r == 5'd0, "frame position not cleared")

endmodule

FILE: design/rcfd_back.sv
// ---------------------------------------------------------------------------
// rcfd_back
// Pops frame descriptors and emits the result transfers for each frame.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "radio_channel_frame_decoder_defines.svh"

module rcfd_back #(
  parameter int NUM_CHANNELS = rcfd_pkg::NUM_CHANNELS_DEF,
  localparam int IDXW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  input  rcfd_pkg::desc_t     q_head,
  output logic                q_pop,
  input  logic [3:0]          channel_limit,
  output logic                ram_re,
  output logic [IDXW:0]       ram_raddr,
  input  logic [15:0]         ram_rdata,
  output logic                out_valid,
  input  logic                out_ready,
  output rcfd_pkg::result_t   out_res,
  output logic                frame_done
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SINGLE,
    S_FETCH,
    S_EMIT
  } state_t;

  state_t            state_r, state_nxt;
  rcfd_pkg::desc_t   desc_r, desc_nxt;
  logic [3:0]        ch_r, ch_nxt;
  logic [3:0]        n_r, n_nxt;
  logic              out_valid_r, out_valid_nxt;
  rcfd_pkg::result_t res_r, res_nxt;

  logic              out_free, load;
  logic [3:0]        n_lim;

  assign out_free  = !out_valid_r || out_ready;
  assign n_lim     = (channel_limit > 4'(NUM_CHANNELS)) ? 4'(NUM_CHANNELS) : channel_limit;
  assign ram_raddr = {desc_r.bank, ch_r[IDXW-1:0]};
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    state_nxt = state_r;
    desc_nxt  = desc_r;
    ch_nxt    = ch_r;
    n_nxt     = n_r;
    res_nxt   = res_r;
    load      = 1'b0;
    q_pop     = 1'b0;
    ram_re    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          desc_nxt = q_head;
          ch_nxt   = 4'd0;
          n_nxt    = n_lim;
          if (q_head.status == rcfd_pkg::ST_CHANNEL && n_lim != 4'd0) begin
            state_nxt = S_FETCH;
          end else begin
            state_nxt = S_SINGLE;
            if (q_head.status == rcfd_pkg::ST_CHANNEL) begin
              desc_nxt.status = rcfd_pkg::ST_NO_CHANNELS;
            end
          end
        end
      end
      S_SINGLE: begin
        if (out_free) begin
          load                  = 1'b1;
          res_nxt.status        = desc_r.status;
          res_nxt.channel_index = 4'd0;
          res_nxt.channel_value = 15'd0;
          res_nxt.last          = 1'b1;
          res_nxt.frame_drops   = desc_r.frame_drops;
          res_nxt.crc_drops     = desc_r.crc_drops;
          state_nxt             = S_IDLE;
        end
      end
      S_FETCH: begin
        ram_re    = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          load                  = 1'b1;
          res_nxt.status        = rcfd_pkg::ST_CHANNEL;
          res_nxt.channel_index = ch_r;
          res_nxt.channel_value = {1'b0, ram_rdata[15:2]} + rcfd_pkg::VALUE_OFFSET;
          res_nxt.last          = (ch_r + 4'd1 == n_r);
          res_nxt.frame_drops   = desc_r.frame_drops;
          res_nxt.crc_drops     = desc_r.crc_drops;
          ch_nxt                = ch_r + 4'd1;
          state_nxt             = (ch_r + 4'd1 == n_r) ? S_IDLE : S_FETCH;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    frame_done    = load && res_nxt.last;
    out_valid_nxt = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    desc_r <= desc_nxt;
    ch_r   <= ch_nxt;
    n_r    <= n_nxt;
    res_r  <= res_nxt;
  end

  `RCFD_ASSERT_IMPLY(a_non_channel_zero,
    out_valid_r && res_r.status != rcfd_pkg::ST_CHANNEL,
    res_r.channel_index == 4'd0 && res_r.channel_value == 15'd0 && res_r.last,
    "non-channel result carries channel data")
  `RCFD_ASSERT_NEXT(a_done_to_idle, frame_done, state_r == S_IDLE,
    "back end busy after last result")

endmodule

FILE: design/radio_channel_frame_decoder.sv
// Sequence: the final byte of a frame is queued in the cycle it is taken; the back end
// then pops it and presents one result (single-result frames), or, for channel frames,
// reads the RAM and then loads each channel result in turn (RAM read + load).
// Throughput: one tick or byte per cycle while fewer than two frames are in flight.
// Reset (rst_n low, synchronous): counters, gap timer and queue clear; registers
// take gap_limit 3000 and channel_limit NUM_CHANNELS.
// ---------------------------------------------------------------------------
// radio_channel_frame_decoder
// Receiver frame decoder: gap framing, start byte and CRC-16 check, channel
// value extraction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module radio_channel_frame_decoder #(
  parameter int NUM_CHANNELS = rcfd_pkg::NUM_CHANNELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,  // [7:0] rx_byte
  input  logic                               in_tuser,  // [0] func (0 tick, 1 byte)
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [3:0] channel_index, [18:4] channel_value, [50:19] frame_drop_count,
  // [82:51] crc_drop_count, [87:83] zero
  output logic [87:0]                        out_tdata,
  output logic [1:0]                         out_tuser, // [1:0] status
  output logic                               out_tlast, // last result of the frame
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rcfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rcfd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IDXW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  // Configuration registers. Issue writes only while the block is idle; the block does not enforce this.
  logic [15:0] gap_limit_r, gap_limit_nxt;
  logic [3:0]  ch_limit_r, ch_limit_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    gap_limit_nxt = gap_limit_r;
    ch_limit_nxt  = ch_limit_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        rcfd_pkg::REG_GAP_LIMIT:     gap_limit_nxt = cfg_data[15:0];
        rcfd_pkg::REG_CHANNEL_LIMIT: ch_limit_nxt  = cfg_data[3:0];
        default: ;  // unused index: write ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_limit_r <= rcfd_pkg::GAP_RESET;
      ch_limit_r  <= 4'(NUM_CHANNELS);
    end else begin
      gap_limit_r <= gap_limit_nxt;
      ch_limit_r  <= ch_limit_nxt;
    end
  end

  // Front/back link
  logic              push, pop, q_empty, q_full, frame_done;
  rcfd_pkg::desc_t   push_desc, q_head;

  // Channel word RAM: two banks of 2**IDXW words (NUM_CHANNELS used), bank picked per frame so
  // the front can collect the next frame while the back still reads the last.
  logic              ram_we, ram_re;
  logic [IDXW:0]     ram_waddr, ram_raddr;
  logic [15:0]       ram_wdata, ram_rdata;

  rcfd_pkg::result_t res;

  rcfd_front #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_func    (rcfd_pkg::func_t'(in_tuser)),
    .in_byte    (in_tdata),
    .in_ready   (in_tready),
    .gap_limit  (gap_limit_r),
    .push       (push),
    .push_desc  (push_desc),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .frame_done (frame_done)
  );

  rcfd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .empty     (q_empty),
    .full      (q_full),
    .head      (q_head)
  );

  rcfd_ram #(
    .WIDTH (16),
    .DEPTH (2 ** (IDXW + 1))
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rcfd_back #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (pop),
    .channel_limit (ch_limit_r),
    .ram_re        (ram_re),
    .ram_raddr     (ram_raddr),
    .ram_rdata     (ram_rdata),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_res       (res),
    .frame_done    (frame_done)
  );

  // Result packing
  assign out_tuser = res.status;
  assign out_tlast = res.last;
  assign out_tdata = {5'd0, res.crc_drops, res.frame_drops,
                      res.channel_value, res.channel_index};

  // q_full is covered by the in-flight limit in the front; kept for the queue check.
  logic unused_q_full;
  assign unused_q_full = q_full;

endmodule

FILE: sim/tb_radio_channel_frame_decoder.sv
// ---------------------------------------------------------------------------
// tb_radio_channel_frame_decoder
// Self-checking bench for the receiver frame decoder. A queue of tick and byte
// transfers is built phase by phase. Each phase after the first sets gap_limit and
// channel_limit, then sends directed or random frames: good frames, bad start
// bytes, CRC errors, truncated frames and noise. Every accepted input transfer
// runs through a local decoder model, which queues the results it expects.
// Each result transfer is checked field by field against the oldest entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_radio_channel_frame_decoder;
  import rcfd_pkg::*;

  localparam int NCH = NUM_CHANNELS_DEF;

  // ---------------------------------------------------------------------------
  // Types
  // ---------------------------------------------------------------------------
  typedef struct {
    func_t      kind;
    logic [7:0] data;
  } feed_t;

  typedef struct {
    status_t     st;
    logic [3:0]  idx;
    logic [14:0] val;
    logic        last;
    logic [31:0] fdrops;
    logic [31:0] cdrops;
  } frame_result_t;

  typedef enum int {FK_GOOD, FK_BAD_START, FK_BAD_CRC} frame_kind_t;
  typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_EXTREMES} fill_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [7:0]            in_tdata = 8'h00;     // [7:0] rx_byte
  logic                  in_tuser = 1'b0;      // [0] func (0 tick, 1 byte)
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [3:0] channel_index, [18:4] channel_value, [50:19] frame_drop_count,
  // [82:51] crc_drop_count, [87:83] zero
  logic [87:0]           out_tdata;
  logic [1:0]            out_tuser;            // [1:0] status
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  radio_channel_frame_decoder #(
    .NUM_CHANNELS (NCH)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Bench state
  // ---------------------------------------------------------------------------
  feed_t         feed_q[$];           // transfers waiting for the driver
  frame_result_t frame_results_q[$];  // decoded results not yet seen on out_*
  feed_t         next_feed;
  int            items_queued = 0;
  int            items_done = 0;
  int            src_wait = 0;
  int            sink_wait = 0;
  bit            quiet_mode = 1'b0;   // no idling on either side while set
  int            err_count = 0;
  int            results_seen = 0;
  int            n_channels = 0;
  int            n_bad_start = 0;
  int            n_crc_fail = 0;
  int            n_no_chan = 0;
  int            cfg_writes = 0;

  // Decoder model state, same reset values as the block
  logic [15:0]   pr_gap = GAP_RESET;
  logic [3:0]    pr_chlim = 4'(NCH);
  int            pr_count = 0;
  logic [15:0]   pr_idle = '0;
  logic [15:0]   pr_crc = '0;
  logic [7:0]    pr_buf[FRAME_LEN];
  logic [31:0]   pr_frame_drops = '0;
  logic [31:0]   pr_crc_drops = '0;

  // Generator's view of the framing, so well-formed frames land aligned
  int            gen_pos = 0;
  int            gen_idle = 0;
  int            gen_gap = GAP_RESET;

  // ---------------------------------------------------------------------------
  // CRC-16 CCITT, bit-serial form, MSB of the byte first
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] ccitt_update(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc;
    for (int k = 0; k < 8; k++) begin
      if (r[15] ^ b[7-k]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Mostly no gap, often a short one, rarely a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_mode || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Decoder model: one accepted transfer in, zero or more results queued
  // ---------------------------------------------------------------------------
  task automatic queue_result(input status_t st, input logic [3:0] idx,
                              input logic [14:0] val, input logic last);
    frame_result_t w;
    w.st     = st;
    w.idx    = idx;
    w.val    = val;
    w.last   = last;
    w.fdrops = pr_frame_drops;
    w.cdrops = pr_crc_drops;
    frame_results_q.push_back(w);
  endtask

  task automatic decode_feed_item(input func_t kind, input logic [7:0] b);
    logic [15:0] word;
    int          n;
    if (kind == FUNC_TICK) begin
      if (pr_idle != 16'hFFFF) pr_idle++;
      return;
    end
    // gap longer than the limit throws away a partial frame
    if (pr_idle > pr_gap && pr_count != 0) begin
      pr_frame_drops++;
      pr_count = 0;
    end
    pr_idle = '0;
    if (pr_count == 0) pr_crc = '0;
    pr_buf[pr_count] = b;
    if (pr_count <= CRC_LAST_BYTE) pr_crc = ccitt_update(pr_crc, b);
    pr_count++;
    if (pr_count < FRAME_LEN) return;
    pr_count = 0;

    if (pr_buf[0] != START_MARK) begin
      pr_frame_drops++;
      queue_result(ST_BAD_START, '0, '0, 1'b1);
      return;
    end
    if (pr_crc != {pr_buf[25], pr_buf[26]}) begin
      pr_crc_drops++;
      queue_result(ST_CRC_FAIL, '0, '0, 1'b1);
      return;
    end
    n = (pr_chlim > NCH) ? NCH : int'(pr_chlim);
    if (n == 0) begin
      queue_result(ST_NO_CHANNELS, '0, '0, 1'b1);
      return;
    end
    for (int c = 0; c < n; c++) begin
      word = {pr_buf[1 + 2*c], pr_buf[2 + 2*c]};
      queue_result(ST_CHANNEL, 4'(c), 15'(word >> 2) + VALUE_OFFSET, c == n - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: pops the feed queue, random gaps between transfers
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        decode_feed_item(func_t'(in_tuser), in_tdata);
        items_done++;
      end
      // slot is free unless a transfer is stalled
      if (!in_tvalid || in_tready) begin
        if (src_wait > 0) begin
          in_tvalid <= 1'b0;
          src_wait--;
        end else if (feed_q.size() != 0) begin
          next_feed = feed_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser  <= next_feed.kind;
          in_tdata  <= next_feed.data;
          src_wait  = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and backpressure
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (err_count < 40) begin
      $display("%0t ns: mismatch on %s, want 0x%0h got 0x%0h", $time, what, want, got);
    end
    err_count++;
  endtask

  task automatic check_result();
    frame_result_t w;
    status_t       got_st;
    got_st = status_t'(out_tuser);
    results_seen++;
    if (frame_results_q.size() == 0) begin
      report_mismatch("result with nothing expected, status", '0, 32'(out_tuser));
      return;
    end
    w = frame_results_q.pop_front();
    if (got_st != w.st)                report_mismatch("status", 32'(w.st), 32'(got_st));
    if (out_tdata[3:0] != w.idx)       report_mismatch("channel_index", 32'(w.idx),
                                                       32'(out_tdata[3:0]));
    if (out_tdata[18:4] != w.val)      report_mismatch("channel_value", 32'(w.val),
                                                       32'(out_tdata[18:4]));
    if (out_tlast != w.last)           report_mismatch("last", 32'(w.last), 32'(out_tlast));
    if (out_tdata[50:19] != w.fdrops)  report_mismatch("frame_drop_count", w.fdrops,
                                                       out_tdata[50:19]);
    if (out_tdata[82:51] != w.cdrops)  report_mismatch("crc_drop_count", w.cdrops,
                                                       out_tdata[82:51]);
    if (out_tdata[87:83] != '0)        report_mismatch("tdata pad", '0, 32'(out_tdata[87:83]));
    case (w.st)
      ST_CHANNEL:     n_channels++;
      ST_BAD_START:   n_bad_start++;
      ST_CRC_FAIL:    n_crc_fail++;
      ST_NO_CHANNELS: n_no_chan++;
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_result();
      if (sink_wait > 0) begin
        out_tready <= 1'b0;
        sink_wait--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) sink_wait = pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus builders (zero time; they only fill the feed queue)
  // ---------------------------------------------------------------------------
  task automatic add_tick();
    feed_q.push_back('{kind: FUNC_TICK, data: 8'($urandom)});
    items_queued++;
    if (gen_idle < 65535) gen_idle++;
  endtask

  task automatic add_byte(input logic [7:0] b);
    feed_q.push_back('{kind: FUNC_BYTE, data: b});
    items_queued++;
    if (gen_idle > gen_gap && gen_pos != 0) gen_pos = 0;
    gen_idle = 0;
    gen_pos++;
    if (gen_pos == FRAME_LEN) gen_pos = 0;
  endtask

  // Get back to a frame boundary: a gap drop when the limit is reachable,
  // filler bytes to close the frame otherwise.
  task automatic align_frame();
    if (gen_pos == 0) return;
    if (gen_gap < 4000) begin
      while (gen_idle <= gen_gap) add_tick();
    end else begin
      while (gen_pos != 0) add_byte(8'($urandom));
    end
  endtask

  task automatic send_frame(input frame_kind_t kind, input fill_t fill);
    logic [7:0]  fb[FRAME_LEN];
    logic [15:0] crc;
    int          burst;
    align_frame();
    fb[0] = START_MARK;
    if (kind == FK_BAD_START) begin
      do fb[0] = 8'($urandom); while (fb[0] == START_MARK);
    end
    for (int i = 1; i <= CRC_LAST_BYTE; i++) begin
      case (fill)
        FILL_ZERO:     fb[i] = 8'h00;
        FILL_ONES:     fb[i] = 8'hFF;
        FILL_EXTREMES: fb[i] = ((i - 1) % 4 < 2) ? 8'hFF : 8'h00;
        default:       fb[i] = 8'($urandom);
      endcase
    end
    crc = '0;
    for (int i = 0; i <= CRC_LAST_BYTE; i++) crc = ccitt_update(crc, fb[i]);
    if (kind == FK_BAD_CRC) crc ^= 16'($urandom_range(1, 65535));
    fb[25] = crc[15:8];
    fb[26] = crc[7:0];
    for (int i = 0; i < FRAME_LEN; i++) begin
      add_byte(fb[i]);
      // short tick runs inside the frame, never long enough to break it
      if (i < FRAME_LEN - 1 && gen_gap >= 1 && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, (gen_gap < 3) ? gen_gap : 3);
        repeat (burst) add_tick();
      end
    end
  endtask

  task automatic send_truncated(input int nbytes);
    align_frame();
    add_byte(($urandom_range(0, 1) != 0) ? START_MARK : 8'($urandom));
    repeat (nbytes - 1) add_byte(8'($urandom));
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 6)) begin
      if ($urandom_range(0, 1) != 0) add_byte(8'($urandom));
      else add_tick();
    end
  endtask

  function automatic fill_t random_fill();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return FILL_RANDOM;
    if (r == 7) return FILL_ZERO;
    if (r == 8) return FILL_ONES;
    return FILL_EXTREMES;
  endfunction

  // ---------------------------------------------------------------------------
  // Sequencing helpers (consume time)
  // ---------------------------------------------------------------------------
  task automatic wait_drained();
    do @(posedge clk); while (items_done != items_queued || frame_results_q.size() != 0);
    // frames still in flight give no result until complete; let the pipe settle
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_GAP_LIMIT) pr_gap = val;
    else if (idx == REG_CHANNEL_LIMIT) pr_chlim = val[3:0];
    cfg_writes++;
  endtask

  task automatic set_config(input int gap, input int chlim, input bit quiet);
    wait_drained();
    cfg_write(REG_GAP_LIMIT, 16'(gap));
    // upper bits of the channel limit write are junk; only [3:0] count
    cfg_write(REG_CHANNEL_LIMIT, {12'($urandom), 4'(chlim)});
    gen_gap    = gap;
    quiet_mode = quiet;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset register values (gap 3000, 12 channels): lowest and highest words
    send_frame(FK_GOOD, FILL_EXTREMES);

    // Short gap limit from here on; a limit of 15 saturates at NCH
    set_config(2, 15, 1'b0);
    // idle run with nothing buffered: no drop may be counted
    repeat (4) add_tick();
    send_frame(FK_GOOD, FILL_ZERO);       // lowest channel values
    send_frame(FK_GOOD, FILL_ONES);       // highest channel values
    send_frame(FK_BAD_START, FILL_RANDOM);
    send_frame(FK_BAD_CRC, FILL_RANDOM);
    // partial frame dropped by a gap; the count shows on the next frame
    send_truncated(10);
    send_frame(FK_GOOD, FILL_RANDOM);

    // zero-channel frame, no idling on either side
    set_config(1, 0, 1'b1);
    send_frame(FK_GOOD, FILL_RANDOM);

    // gap limit out of reach: noise bytes are closed out by filler bytes
    set_config(65535, 5, 1'b0);
    send_noise();
    send_frame(FK_GOOD, random_fill());

    wait_drained();
    repeat (20) @(posedge clk);
    if (frame_results_q.size() != 0) begin
      report_mismatch("results never seen", 32'(frame_results_q.size()), '0);
    end

    $display("Run covered %0d input transfers and %0d results over %0d register writes",
             items_done, results_seen, cfg_writes);
    $display("  %0d channel values, %0d bad start, %0d crc fail, %0d zero-channel frames",
             n_channels, n_bad_start, n_crc_fail, n_no_chan);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
